[hdl/abef_pkg.sv]
// Shared constants, types and the band edge table of the band energy fingerprint.
package abef_pkg;

    localparam int SR_W      = 17;
    localparam int FB_W      = 12;
    localparam int CFG_W     = 17;
    localparam int CFG_IDX_W = 1;

    localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_RATE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_FFT_BINS    = 1'b1;

    localparam logic [SR_W-1:0] SR_RESET = 17'd5000;
    localparam logic [FB_W-1:0] FB_RESET = 12'd2048;

    localparam int NUM_BANDS = 33;
    localparam int BAND_W    = 6;
    localparam int SUM_W     = 40;
    localparam int WORD_W    = 32;
    localparam int EDGE_W    = 21;

    // frequencies are held in mHz, so bin frequency gets scaled by this
    localparam logic [9:0] MHZ_SCALE = 10'd1000;

    typedef logic [SUM_W-1:0]  t_sum;
    typedef logic [EDGE_W-1:0] t_edge;

    // Band edges in mHz; entry 0 is the low limit, entry NUM_BANDS the high limit.
    function automatic t_edge edge_mhz(input logic [BAND_W-1:0] k);
        t_edge e;
        case (k)
            6'd0:    e = 21'd300000;
            6'd1:    e = 21'd317752;
            6'd2:    e = 21'd336554;
            6'd3:    e = 21'd356469;
            6'd4:    e = 21'd377563;
            6'd5:    e = 21'd399904;
            6'd6:    e = 21'd423568;
            6'd7:    e = 21'd448632;
            6'd8:    e = 21'd475178;
            6'd9:    e = 21'd503296;
            6'd10:   e = 21'd533078;
            6'd11:   e = 21'd564622;
            6'd12:   e = 21'd598032;
            6'd13:   e = 21'd633419;
            6'd14:   e = 21'd670901;
            6'd15:   e = 21'd710600;
            6'd16:   e = 21'd752648;
            6'd17:   e = 21'd797185;
            6'd18:   e = 21'd844357;
            6'd19:   e = 21'd894320;
            6'd20:   e = 21'd947240;
            6'd21:   e = 21'd1003290;
            6'd22:   e = 21'd1062660;
            6'd23:   e = 21'd1125540;
            6'd24:   e = 21'd1192140;
            6'd25:   e = 21'd1262680;
            6'd26:   e = 21'd1337400;
            6'd27:   e = 21'd1416540;
            6'd28:   e = 21'd1500360;
            6'd29:   e = 21'd1589140;
            6'd30:   e = 21'd1683170;
            6'd31:   e = 21'd1782770;
            6'd32:   e = 21'd1888270;
            6'd33:   e = 21'd2000000;
            default: e = '0;
        endcase
        return e;
    endfunction

endpackage

[hdl/abef_if.sv]
// Valid/ready channels of the band energy fingerprint: FFT bin in, fingerprint word out.
interface abef_bin_if #(
    parameter int SAMPLE_BITS = 24,
    parameter int IDX_W       = 11
);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] bin_real;
    logic signed [SAMPLE_BITS-1:0] bin_imag;
    logic [IDX_W-1:0]              bin_index;
    logic                          last_bin;
    logic                          new_track;

    modport source (output valid, bin_real, bin_imag, bin_index, last_bin, new_track,
                    input ready);
    modport sink (input valid, bin_real, bin_imag, bin_index, last_bin, new_track,
                  output ready);
endinterface

interface abef_word_if;
    logic                         valid;
    logic                         ready;
    logic [abef_pkg::WORD_W-1:0]  fingerprint_word;
    logic                         first_frame;

    modport source (output valid, fingerprint_word, first_frame, input ready);
    modport sink (input valid, fingerprint_word, first_frame, output ready);
endinterface

[hdl/audio_band_energy_fingerprint.sv]
// Band energy audio fingerprint: bins in, one 32-bit sub-fingerprint per frame out.
//
// i_bin carries one FFT bin per word (real, imaginary, index, last_bin, new_track);
// o_fp carries one fingerprint word per frame, on the bin that has last_bin set.
// Both are valid/ready; a word moves on a clock edge with valid and ready high.
// Write sample_rate (index 0), fft_bins (index 1) via i_cfg_* only while idle (unenforced).
//
// One bin is worked on at a time; i_bin.ready is high only while idle. A single
// multiplier is shared under a sequencer: bin frequency, range check, a six
// step binary search of the band edges, two squares and a square root at one
// result bit per cycle, the root using the one subtract unit. A bin outside
// 300..2000 Hz skips the search, squares and root. A last bin then sweeps the
// 33 band sums, read one entry per cycle from the two banks, and the word
// lands in the output register. The output register lets the next bin be
// taken while the word waits; a frame that ends while the previous word is
// still unread waits for it to be taken. Band sums live in two RAM banks that
// swap roles each frame; per-entry valid flags make the new current bank read
// as zero, so no clearing pass is needed. Reset (synchronous) restores the
// register defaults and empties both banks.
module audio_band_energy_fingerprint #(
    parameter int FFT_BINS    = 2048,
    parameter int SAMPLE_BITS = 24
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [abef_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [abef_pkg::CFG_W-1:0]      i_cfg_wdata,
    abef_bin_if.sink                        i_bin,
    abef_word_if.source                     o_fp
);
    import abef_pkg::*;

    localparam int IDX_W = $clog2(FFT_BINS);
    localparam int NUM_W = IDX_W + 1 + SR_W + 10;
    localparam int EP_W  = EDGE_W + FB_W;
    localparam int FR_W  = IDX_W + 1 + SR_W;
    localparam int MUL_W = (SAMPLE_BITS > FR_W) ? SAMPLE_BITS : FR_W;
    localparam int RAD_W = 2 * SAMPLE_BITS;
    localparam int RMW   = SAMPLE_BITS + 4;
    localparam int CNT_W = $clog2(SAMPLE_BITS + 1);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_MUL1   = 4'd1;
    localparam logic [3:0] S_MUL2   = 4'd2;
    localparam logic [3:0] S_LOEDGE = 4'd3;
    localparam logic [3:0] S_HIEDGE = 4'd4;
    localparam logic [3:0] S_RANGE  = 4'd5;
    localparam logic [3:0] S_SRCH   = 4'd6;
    localparam logic [3:0] S_SCMP   = 4'd7;
    localparam logic [3:0] S_SQ1    = 4'd8;
    localparam logic [3:0] S_SQ2    = 4'd9;
    localparam logic [3:0] S_SQ3    = 4'd10;
    localparam logic [3:0] S_ROOT   = 4'd11;
    localparam logic [3:0] S_ACC    = 4'd12;
    localparam logic [3:0] S_WORD   = 4'd13;
    localparam logic [3:0] S_OUT    = 4'd14;

    // control
    logic [3:0]             r_state, n_state;
    logic [SR_W-1:0]        r_sr;
    logic [FB_W-1:0]        r_fft;
    logic                   r_have;
    logic                   r_cur;
    logic [NUM_BANDS-1:0]   r_vld [2];
    logic                   r_ov;

    // payload
    logic [SAMPLE_BITS-1:0] r_re, r_im;
    logic [IDX_W:0]         r_idx1;
    logic                   r_last;
    logic [2*MUL_W-1:0]     r_prod;
    logic [NUM_W-1:0]       r_num;
    logic                   r_lo_ok;
    logic [BAND_W-1:0]      r_band;
    logic [BAND_W-1:0]      r_step;
    logic [RAD_W-1:0]       r_sq;
    logic [RAD_W-1:0]       r_rad;
    logic [RMW-1:0]         r_rem;
    logic [SAMPLE_BITS-1:0] r_root;
    logic [CNT_W-1:0]       r_cnt;
    logic [BAND_W-1:0]      r_k, r_kd;
    logic                   r_dv;
    t_sum                   r_ep, r_pp;
    logic [WORD_W-1:0]      r_acc;
    logic [WORD_W-1:0]      r_word;
    logic                   r_first;

    logic                   in_acc;
    logic                   out_free;
    logic [SAMPLE_BITS-1:0] in_re, in_im, abs_re, abs_im;
    logic [MUL_W-1:0]       mul_a, mul_b;
    logic [2*MUL_W-1:0]     mul_p;
    logic [NUM_W-1:0]       edge_prod;
    logic [BAND_W:0]        cand;
    logic                   cand_ok;
    logic                   in_range;
    logic [RMW-1:0]         rem_sh, trial;
    logic [SUM_W:0]         acc_sum;
    t_sum                   acc_cur, sat_sum;
    t_sum                   rd [2];
    t_sum                   rd_cur, rd_prev;
    t_sum                   cur_e, prev_p;
    logic                   gt;
    logic [4:0]             pos;
    logic [BAND_W-1:0]      ram_addr;
    logic                   ram_we;

    assign in_acc   = i_bin.valid && i_bin.ready;
    assign out_free = !r_ov || o_fp.ready;

    assign in_re  = i_bin.bin_real;
    assign in_im  = i_bin.bin_imag;
    assign abs_re = in_re[SAMPLE_BITS-1] ? (~in_re + 1'b1) : in_re;
    assign abs_im = in_im[SAMPLE_BITS-1] ? (~in_im + 1'b1) : in_im;

    assign cand    = (BAND_W+1)'(r_band) + (BAND_W+1)'(r_step);
    assign cand_ok = cand <= (BAND_W+1)'(NUM_BANDS - 1);

    // shared multiplier, operands picked by the sequencer
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (r_state)
            S_MUL1: begin
                mul_a = MUL_W'(r_idx1);
                mul_b = MUL_W'(r_sr);
            end
            S_MUL2: begin
                mul_a = r_prod[MUL_W-1:0];
                mul_b = MUL_W'(MHZ_SCALE);
            end
            S_LOEDGE: begin
                mul_a = MUL_W'(edge_mhz(BAND_W'(0)));
                mul_b = MUL_W'(r_fft);
            end
            S_HIEDGE: begin
                mul_a = MUL_W'(edge_mhz(BAND_W'(NUM_BANDS)));
                mul_b = MUL_W'(r_fft);
            end
            S_SRCH: begin
                mul_a = MUL_W'(edge_mhz(cand[BAND_W-1:0]));
                mul_b = MUL_W'(r_fft);
            end
            S_SQ1: begin
                mul_a = MUL_W'(r_re);
                mul_b = MUL_W'(r_re);
            end
            S_SQ2: begin
                mul_a = MUL_W'(r_im);
                mul_b = MUL_W'(r_im);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p     = mul_a * mul_b;
    assign edge_prod = NUM_W'(r_prod[EP_W-1:0]);
    assign in_range  = (r_fft != '0) && r_lo_ok && (r_num <= edge_prod);

    // square root, one result bit per step
    assign rem_sh = {r_rem[RMW-3:0], r_rad[RAD_W-1:RAD_W-2]};
    assign trial  = RMW'({r_root, 2'b01});

    assign rd_cur  = r_cur ? rd[1] : rd[0];
    assign rd_prev = r_cur ? rd[0] : rd[1];

    assign acc_cur = r_vld[r_cur][r_band] ? rd_cur : '0;
    assign acc_sum = (SUM_W+1)'(acc_cur) + (SUM_W+1)'(r_root);
    assign sat_sum = acc_sum[SUM_W] ? '1 : acc_sum[SUM_W-1:0];

    // word sweep: E[j]-E[j+1] > P[j]-P[j+1]  <=>  E[j]+P[j+1] > E[j+1]+P[j]
    assign cur_e  = r_vld[r_cur][r_kd] ? rd_cur : '0;
    assign prev_p = (r_have && r_vld[~r_cur][r_kd]) ? rd_prev : '0;
    assign gt     = ((SUM_W+1)'(r_ep) + (SUM_W+1)'(prev_p))
                  > ((SUM_W+1)'(cur_e) + (SUM_W+1)'(r_pp));
    assign pos    = 5'(WORD_W - int'(r_kd));

    assign ram_addr = (r_state == S_WORD) ? r_k : r_band;
    assign ram_we   = (r_state == S_ACC);

    for (genvar b = 0; b < 2; b++) begin : g_bank
        abef_ram #(
            .WIDTH (SUM_W),
            .DEPTH (NUM_BANDS)
        ) u_bank (
            .i_clk   (i_clk),
            .i_we    (ram_we && (r_cur == 1'(b))),
            .i_waddr (r_band),
            .i_wdata (sat_sum),
            .i_raddr (ram_addr),
            .o_rdata (rd[b])
        );
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:   n_state = in_acc ? S_MUL1 : S_IDLE;
            S_MUL1:   n_state = S_MUL2;
            S_MUL2:   n_state = S_LOEDGE;
            S_LOEDGE: n_state = S_HIEDGE;
            S_HIEDGE: n_state = S_RANGE;
            S_RANGE: begin
                if (in_range) begin
                    n_state = S_SRCH;
                end else begin
                    n_state = r_last ? S_WORD : S_IDLE;
                end
            end
            S_SRCH:   n_state = S_SCMP;
            S_SCMP:   n_state = r_step[0] ? S_SQ1 : S_SRCH;
            S_SQ1:    n_state = S_SQ2;
            S_SQ2:    n_state = S_SQ3;
            S_SQ3:    n_state = S_ROOT;
            S_ROOT:   n_state = (r_cnt == CNT_W'(SAMPLE_BITS - 1)) ? S_ACC : S_ROOT;
            S_ACC:    n_state = r_last ? S_WORD : S_IDLE;
            S_WORD:   n_state = (r_dv && r_kd == BAND_W'(NUM_BANDS - 1)) ? S_OUT : S_WORD;
            S_OUT:    n_state = out_free ? S_IDLE : S_OUT;
            default:  n_state = S_IDLE;
        endcase
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sr  <= SR_RESET;
            r_fft <= FB_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_SAMPLE_RATE: r_sr  <= i_cfg_wdata[SR_W-1:0];
                REG_FFT_BINS:    r_fft <= i_cfg_wdata[FB_W-1:0];
                default: ;
            endcase
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_have  <= 1'b0;
            r_cur   <= 1'b0;
            r_vld   <= '{default: '0};
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            if (in_acc && i_bin.new_track) begin
                r_have <= 1'b0;
            end
            if (r_state == S_ACC) begin
                r_vld[r_cur][r_band] <= 1'b1;
            end
            if (r_state == S_OUT && out_free) begin
                // current sums become the previous frame, the old bank reads as empty
                r_ov          <= 1'b1;
                r_have        <= 1'b1;
                r_cur         <= ~r_cur;
                r_vld[~r_cur] <= '0;
            end else if (r_ov && o_fp.ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        r_prod <= mul_p;
        if (in_acc) begin
            r_re   <= abs_re;
            r_im   <= abs_im;
            r_idx1 <= (IDX_W+1)'(i_bin.bin_index) + 1'b1;
            r_last <= i_bin.last_bin;
        end
        if (r_state == S_MUL2) begin
            r_num <= mul_p[NUM_W-1:0];
        end
        if (r_state == S_HIEDGE) begin
            r_lo_ok <= r_num >= edge_prod;
        end
        if (r_state == S_RANGE) begin
            r_band <= '0;
            r_step <= BAND_W'(1) << (BAND_W - 1);
        end
        if (r_state == S_SCMP) begin
            if (cand_ok && edge_prod <= r_num) begin
                r_band <= cand[BAND_W-1:0];
            end
            r_step <= r_step >> 1;
        end
        if (r_state == S_SQ2) begin
            r_sq <= r_prod[RAD_W-1:0];
        end
        if (r_state == S_SQ3) begin
            r_rad  <= r_sq + r_prod[RAD_W-1:0];
            r_rem  <= '0;
            r_root <= '0;
            r_cnt  <= '0;
        end
        if (r_state == S_ROOT) begin
            if (rem_sh >= trial) begin
                r_rem  <= rem_sh - trial;
                r_root <= {r_root[SAMPLE_BITS-2:0], 1'b1};
            end else begin
                r_rem  <= rem_sh;
                r_root <= {r_root[SAMPLE_BITS-2:0], 1'b0};
            end
            r_rad <= r_rad << 2;
            r_cnt <= r_cnt + 1'b1;
        end
        if (n_state == S_WORD && r_state != S_WORD) begin
            r_k   <= '0;
            r_dv  <= 1'b0;
            r_acc <= '0;
        end
        if (r_state == S_WORD) begin
            if (r_k != BAND_W'(NUM_BANDS - 1)) begin
                r_k <= r_k + 1'b1;
            end
            r_kd <= r_k;
            r_dv <= 1'b1;
            if (r_dv) begin
                r_ep <= cur_e;
                r_pp <= prev_p;
                if (r_kd != '0 && r_kd <= BAND_W'(WORD_W)) begin
                    r_acc[pos] <= gt;
                end
            end
        end
        if (r_state == S_OUT && out_free) begin
            r_word  <= r_acc;
            r_first <= ~r_have;
        end
    end

    assign i_bin.ready         = (r_state == S_IDLE);
    assign o_fp.valid          = r_ov;
    assign o_fp.fingerprint_word = r_word;
    assign o_fp.first_frame    = r_first;

`ifndef NO_ASSERTIONS
    a_bank_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(r_state == S_OUT && out_free) && $past(i_rst_n)) |-> (r_vld[r_cur] == '0))
        else $error("new current bank not emptied at frame end");

    a_band_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ACC) |-> (r_band <= BAND_W'(NUM_BANDS - 1)))
        else $error("band index beyond the last band");

    a_word_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_ov) |-> $past(r_state == S_OUT))
        else $error("word loaded outside the output state");

    a_have_set: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT && out_free) |=> r_have)
        else $error("previous frame flag not set after a word");
`endif

endmodule

[hdl/abef_ram.sv]
// Generic single write port RAM with one registered read port.
module abef_ram #(
    parameter int WIDTH = 40,
    parameter int DEPTH = 33
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

[sim/abef_fp_checker.sv]
// Checker: watches the bin and word channels, predicts each fingerprint word and compares it.
module abef_fp_checker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [abef_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [abef_pkg::CFG_W-1:0]     i_cfg_wdata,
    abef_bin_if                            i_bin,
    abef_word_if                           i_fp,
    output int                             o_errors,
    output int                             o_words_due
);
    import abef_pkg::*;

    localparam longint unsigned SUM_CAP = (64'd1 << SUM_W) - 64'd1;

    // band edges in mHz, low limit first, high limit last
    localparam int unsigned BAND_EDGE_MHZ [NUM_BANDS + 1] = '{
        300000, 317752, 336554, 356469, 377563, 399904, 423568,
        448632, 475178, 503296, 533078, 564622, 598032, 633419,
        670901, 710600, 752648, 797185, 844357, 894320, 947240,
        1003290, 1062660, 1125540, 1192140, 1262680, 1337400,
        1416540, 1500360, 1589140, 1683170, 1782770, 1888270,
        2000000
    };

    typedef struct packed {
        logic [WORD_W-1:0] word;
        logic              first;
    } t_fp;

    logic [SR_W-1:0] rate_hz;
    logic [FB_W-1:0] bins_per_frame;
    t_sum            energy [NUM_BANDS];
    t_sum            prior_energy [NUM_BANDS];
    logic            have_prior;
    t_fp             words_due [$];

    function automatic longint unsigned mag_abs(input logic signed [23:0] v);
        longint s;
        s = v;
        return (s < 0) ? longint'(-s) : longint'(s);
    endfunction

    always @(posedge i_clk) begin : track
        longint unsigned   num, x, r, b, acc, span;
        longint            d;
        int                band;
        logic [WORD_W-1:0] w;
        t_fp               due;
        if (!i_rst_n) begin
            rate_hz        = SR_RESET;
            bins_per_frame = FB_RESET;
            have_prior     = 1'b0;
            for (int j = 0; j < NUM_BANDS; j++) begin
                energy[j]       = '0;
                prior_energy[j] = '0;
            end
            words_due.delete();
            o_errors = 0;
        end else begin
            if (i_fp.valid && i_fp.ready) begin
                if (words_due.size() == 0) begin
                    o_errors++;
                    $display("%0t: unexpected word: expected none, got word %h first %b",
                             $time, i_fp.fingerprint_word, i_fp.first_frame);
                end else begin
                    due = words_due.pop_front();
                    if (due.word !== i_fp.fingerprint_word) begin
                        o_errors++;
                        $display("%0t: fingerprint_word expected %h got %h",
                                 $time, due.word, i_fp.fingerprint_word);
                    end
                    if (due.first !== i_fp.first_frame) begin
                        o_errors++;
                        $display("%0t: first_frame expected %b got %b",
                                 $time, due.first, i_fp.first_frame);
                    end
                end
            end

            if (i_bin.valid && i_bin.ready) begin
                if (i_bin.new_track)
                    have_prior = 1'b0;
                if (bins_per_frame != 0) begin
                    // compare by cross-multiplication, frequency never rounded
                    num  = (64'(i_bin.bin_index) + 64'd1) * 64'(rate_hz) * 64'd1000;
                    span = 64'(bins_per_frame);
                    if (num >= 64'(BAND_EDGE_MHZ[0]) * span &&
                        num <= 64'(BAND_EDGE_MHZ[NUM_BANDS]) * span) begin
                        band = 0;
                        for (int j = 1; j < NUM_BANDS; j++)
                            if (64'(BAND_EDGE_MHZ[j]) * span <= num)
                                band = j;
                        x = mag_abs(i_bin.bin_real) * mag_abs(i_bin.bin_real) +
                            mag_abs(i_bin.bin_imag) * mag_abs(i_bin.bin_imag);
                        // integer square root, two bits per step
                        r = 0;
                        b = 64'd1 << 62;
                        while (b > x)
                            b >>= 2;
                        while (b != 0) begin
                            if (x >= r + b) begin
                                x -= r + b;
                                r = (r >> 1) + b;
                            end else begin
                                r >>= 1;
                            end
                            b >>= 2;
                        end
                        acc = 64'(energy[band]) + r;
                        energy[band] = (acc > SUM_CAP) ? t_sum'(SUM_CAP) : t_sum'(acc);
                    end
                end
                if (i_bin.last_bin) begin
                    w = '0;
                    for (int j = 0; j < WORD_W; j++) begin
                        d = $signed({24'd0, energy[j]}) - $signed({24'd0, energy[j + 1]});
                        if (have_prior)
                            d -= $signed({24'd0, prior_energy[j]}) -
                                 $signed({24'd0, prior_energy[j + 1]});
                        if (d > 0)
                            w[WORD_W - 1 - j] = 1'b1;
                    end
                    due.word  = w;
                    due.first = !have_prior;
                    words_due.insert(words_due.size(), due);
                    for (int j = 0; j < NUM_BANDS; j++) begin
                        prior_energy[j] = energy[j];
                        energy[j]       = '0;
                    end
                    have_prior = 1'b1;
                end
            end

            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_SAMPLE_RATE: rate_hz = i_cfg_wdata[SR_W-1:0];
                    REG_FFT_BINS:    bins_per_frame = i_cfg_wdata[FB_W-1:0];
                    default: ;
                endcase
            end
        end
        o_words_due = words_due.size();
    end

endmodule

[sim/tb_top.sv]
// Testbench top: drives FFT bins and register writes, drains fingerprint words, gives the verdict.
module tb_top;
    import abef_pkg::*;

    localparam int N_PHASES   = 11;
    localparam int PHASE_BINS = 178;

    // rate 0 marks a phase with a random setting
    localparam int unsigned PHASE_RATE [N_PHASES] = '{
        5000, 48000, 8000, 96000, 1, 44100, 22050, 5000, 96000, 11025, 0
    };
    localparam int unsigned PHASE_FRAME_BINS [N_PHASES] = '{
        2048, 2048, 512, 2048, 1, 1024, 256, 0, 1, 64, 0
    };

    localparam logic signed [23:0] S_MAX = 24'sh7FFFFF;
    localparam logic signed [23:0] S_MIN = 24'sh800000;

    logic             i_clk = 1'b0;
    logic             i_rst_n;
    logic             cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0] cfg_wdata;

    int  fail_count;
    int  words_due;
    bit  calm_in;
    bit  calm_out;
    bit  win_ok;
    int  win_lo;
    int  win_hi;

    abef_bin_if #(.SAMPLE_BITS(24), .IDX_W(11)) bin_ch ();
    abef_word_if fp_ch ();

    audio_band_energy_fingerprint dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_wdata (cfg_wdata),
        .i_bin       (bin_ch),
        .o_fp        (fp_ch)
    );

    abef_fp_checker fp_check (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_wdata (cfg_wdata),
        .i_bin       (bin_ch),
        .i_fp        (fp_ch),
        .o_errors    (fail_count),
        .o_words_due (words_due)
    );

    always #5 i_clk = ~i_clk;

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        @(negedge i_clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(negedge i_clk);
        cfg_we    <= 1'b0;
    endtask

    task automatic hold_until_drained(input int settle);
        @(negedge i_clk);
        bin_ch.valid <= 1'b0;
        while (words_due != 0)
            @(negedge i_clk);
        repeat (settle) @(negedge i_clk);
    endtask

    task automatic set_config(input logic [SR_W-1:0] sr, input logic [FB_W-1:0] fb);
        longint unsigned step_mhz, k_lo, k_hi;
        // a bin may still be in flight after the last word, so leave it time
        hold_until_drained(100);
        cfg_write(REG_SAMPLE_RATE, CFG_W'(sr));
        cfg_write(REG_FFT_BINS, CFG_W'(fb));
        // index window whose bins land in 300..2000 Hz
        win_ok = 1'b0;
        if (fb != 0) begin
            step_mhz = 64'(sr) * 64'd1000;
            k_lo = (64'd300000 * 64'(fb) + step_mhz - 64'd1) / step_mhz;
            k_hi = (64'd2000000 * 64'(fb)) / step_mhz;
            if (k_lo == 0)
                k_lo = 1;
            if (k_hi > 2048)
                k_hi = 2048;
            if (k_hi >= k_lo) begin
                win_ok = 1'b1;
                win_lo = int'(k_lo) - 1;
                win_hi = int'(k_hi) - 1;
            end
        end
    endtask

    task automatic send_bin(input logic signed [23:0] re, input logic signed [23:0] im,
                            input logic [10:0] idx, input logic lst, input logic nt);
        int gap;
        if ($urandom_range(0, 63) == 0)
            calm_in = !calm_in;
        gap = calm_in ? 0 : $urandom_range(0, 16);
        @(negedge i_clk);
        if (gap > 0) begin
            bin_ch.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        bin_ch.valid     <= 1'b1;
        bin_ch.bin_real  <= re;
        bin_ch.bin_imag  <= im;
        bin_ch.bin_index <= idx;
        bin_ch.last_bin  <= lst;
        bin_ch.new_track <= nt;
        do @(posedge i_clk); while (!bin_ch.ready);
    endtask

    function automatic logic signed [23:0] pick_sample();
        int unsigned sel;
        logic [31:0] r;
        sel = $urandom_range(0, 15);
        r   = $urandom();
        case (sel)
            0:       return S_MAX;
            1:       return S_MIN;
            2:       return '0;
            3:       return -24'sd1;
            4, 5, 6: return 24'(int'($urandom_range(0, 2000)) - 1000);
            default: return r[23:0];
        endcase
    endfunction

    // word side: stalls drawn per word, with calm stretches
    initial begin : word_sink
        int stall;
        fp_ch.ready = 1'b0;
        calm_out    = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            if ($urandom_range(0, 15) == 0)
                calm_out = !calm_out;
            stall = calm_out ? 0 : $urandom_range(0, 16);
            @(negedge i_clk);
            if (stall > 0) begin
                fp_ch.ready <= 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            fp_ch.ready <= 1'b1;
            do @(posedge i_clk); while (!fp_ch.valid);
        end
    end

    initial begin : bin_source
        int         ph, left, len, k;
        bit         joined, fresh, paused;
        logic [10:0] idx;
        i_rst_n          = 1'b0;
        cfg_we           = 1'b0;
        cfg_index        = '0;
        cfg_wdata        = '0;
        bin_ch.valid     = 1'b0;
        bin_ch.bin_real  = '0;
        bin_ch.bin_imag  = '0;
        bin_ch.bin_index = '0;
        bin_ch.last_bin  = 1'b0;
        bin_ch.new_track = 1'b0;
        calm_in          = 1'b0;
        win_ok           = 1'b0;
        win_lo           = 0;
        win_hi           = 0;
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset setting, 5000 Hz over 2048 bins: bins 122..818 are in range
        send_bin(S_MAX, S_MIN, 11'd122, 1'b0, 1'b1);
        send_bin(S_MIN, S_MAX, 11'd818, 1'b0, 1'b0);
        send_bin(24'sd1, -24'sd1, 11'd121, 1'b0, 1'b0);
        send_bin(S_MAX, S_MAX, 11'd819, 1'b0, 1'b0);
        send_bin('0, '0, 11'd2047, 1'b0, 1'b0);
        send_bin(-24'sd5, 24'sd7, 11'd0, 1'b1, 1'b0);
        send_bin(24'sd1000, '0, 11'd300, 1'b0, 1'b0);
        send_bin(-24'sd70000, 24'sd3, 11'd500, 1'b0, 1'b0);
        send_bin('0, 24'sd123456, 11'd700, 1'b0, 1'b0);
        send_bin(24'sd42, -24'sd42, 11'd400, 1'b1, 1'b0);
        // new track on the closing bin, then new track mid-frame
        send_bin(24'sd5, '0, 11'd200, 1'b1, 1'b1);
        send_bin(24'sd77, '0, 11'd250, 1'b0, 1'b1);
        send_bin(-24'sd300000, 24'sd2, 11'd600, 1'b1, 1'b0);

        // bin 0 sits exactly on the low limit
        set_config(SR_W'(300), FB_W'(1));
        send_bin(24'sd12345, '0, 11'd0, 1'b0, 1'b0);
        send_bin('0, -24'sd5000, 11'd1, 1'b0, 1'b0);
        send_bin(24'sd9, '0, 11'd2, 1'b1, 1'b0);
        // bin 3 sits exactly on the first inner edge
        set_config(SR_W'(79438), FB_W'(1000));
        send_bin(24'sd800, '0, 11'd3, 1'b0, 1'b0);
        send_bin(24'sd999999, '0, 11'd2, 1'b0, 1'b0);
        send_bin(24'sd4, 24'sd3, 11'd24, 1'b1, 1'b0);
        // bin 1 is exactly 2000 Hz
        set_config(SR_W'(1000), FB_W'(1));
        send_bin(24'sd2000, '0, 11'd1, 1'b0, 1'b0);
        send_bin(24'sd1, '0, 11'd0, 1'b0, 1'b0);
        send_bin(24'sd3, '0, 11'd2, 1'b1, 1'b0);
        // zero bins per frame: nothing summed, word still due
        set_config(SR_W'(5000), FB_W'(0));
        send_bin(S_MAX, S_MAX, 11'd500, 1'b0, 1'b0);
        send_bin('0, '0, 11'd1, 1'b1, 1'b0);

        for (ph = 0; ph < N_PHASES; ph++) begin
            if (PHASE_RATE[ph] == 0)
                set_config(SR_W'($urandom_range(1, 96000)), FB_W'($urandom_range(1, 2048)));
            else
                set_config(SR_W'(PHASE_RATE[ph]), FB_W'(PHASE_FRAME_BINS[ph]));
            left   = PHASE_BINS;
            paused = 1'b0;
            while (left > 0) begin
                len = $urandom_range(1, 24);
                if (len > left)
                    len = left;
                // occasionally drop the closing bin so two frames run together
                joined = ($urandom_range(0, 11) == 0);
                fresh  = ($urandom_range(0, 5) == 0);
                for (k = 0; k < len; k++) begin
                    if (win_ok && $urandom_range(0, 4) != 0)
                        idx = 11'($urandom_range(win_lo, win_hi));
                    else
                        idx = 11'($urandom_range(0, 2047));
                    send_bin(pick_sample(), pick_sample(), idx,
                             k == len - 1 && !joined,
                             (k == 0 && fresh) || $urandom_range(0, 39) == 0);
                end
                left -= len;
                if (!paused && 2 * left <= PHASE_BINS) begin
                    hold_until_drained(0);
                    paused = 1'b1;
                end
            end
        end

        hold_until_drained(100);
        if (fail_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    initial begin : watchdog
        #10_000_000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule

[sim.f]
hdl/abef_pkg.sv
hdl/abef_if.sv
hdl/abef_ram.sv
hdl/audio_band_energy_fingerprint.sv
sim/abef_fp_checker.sv
sim/tb_top.sv
